FILE: rtl/core/ipbl_pkg.sv
package ipbl_pkg;

	// Field widths fixed by the interface.
	localparam int CMD_W = 2;
	localparam int IDX_W = 4;
	localparam int PLEN_W = 8;
	localparam int HALF_W = 64;
	localparam int ADDR4_W = 32;
	localparam int ADDR6_W = 128;

	// Default table sizes.
	localparam int V4_ENTRIES_DEF = 16;
	localparam int V6_ENTRIES_DEF = 16;

	// Entries folded together in the first level of the match reduction.
	localparam int GRP = 16;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_CHECK = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WR4 = 2'd1;
	localparam logic [CMD_W-1:0] CMD_WR6 = 2'd2;

	// Write control for one prefix table.
	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] index;
		logic valid;
	} tbl_wr_t;

	// Mask with the top plen of 128 bits set. Lengths above 128 give all ones,
	// and the top 32 bits serve as the IPv4 mask with saturation at 32.
	function automatic logic [ADDR6_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
		logic [ADDR6_W-1:0] m;
		m = '0;
		for (int i = 0; i < ADDR6_W; i++) begin
			m[ADDR6_W-1-i] = (PLEN_W'(i) < plen);
		end
		return m;
	endfunction

endpackage

FILE: rtl/core/ipbl_table.sv
module ipbl_table
	import ipbl_pkg::*;
#(
	parameter int ENTRIES = V4_ENTRIES_DEF,
	parameter int AW = ADDR4_W,
	localparam int NGRP = (ENTRIES + GRP - 1) / GRP
) (
	input  logic            clk,
	input  logic            arst_n,
	input  tbl_wr_t         wr,
	input  logic [AW-1:0]   wr_addr,
	input  logic [AW-1:0]   wr_mask,
	input  logic            chk_en,
	input  logic [AW-1:0]   chk_addr,
	output logic [NGRP-1:0] grp_s3
);

	logic [ENTRIES-1:0] valid_q;
	logic [AW-1:0]      net_q  [ENTRIES];
	logic [AW-1:0]      mask_q [ENTRIES];
	logic [ENTRIES-1:0] match_d;
	logic [ENTRIES-1:0] match_s2;
	logic [NGRP-1:0]    grp_d;

	// One storage slot per entry; the network is kept already masked.
	for (genvar e = 0; e < ENTRIES; e++) begin : g_slot
		localparam logic [31:0] SLOT = 32'(e);
		logic hit;

		assign hit = wr.en && ({{(32-IDX_W){1'b0}}, wr.index} == SLOT);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_q[e] <= 1'b0;
			end else if (hit) begin
				valid_q[e] <= wr.valid;
			end
		end

		always_ff @(posedge clk) begin
			if (hit) begin
				net_q[e] <= wr_addr & wr_mask;
				mask_q[e] <= wr_mask;
			end
		end

		// Per-entry compare lane.
		assign match_d[e] = chk_en && valid_q[e] && ((chk_addr & mask_q[e]) == net_q[e]);
	end

	// Group OR of the registered match bits.
	always_comb begin
		grp_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			for (int j = 0; j < GRP; j++) begin
				if (g * GRP + j < ENTRIES) begin
					grp_d[g] = grp_d[g] | match_s2[g*GRP+j];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_s2 <= '0;
			grp_s3 <= '0;
		end else begin
			match_s2 <= match_d;
			grp_s3 <= grp_d;
		end
	end

endmodule

FILE: rtl/core/ip_prefix_blacklist_match_unit.sv
// Throughput: one beat per cycle while busy is low; every table entry has its own compare lane.
// Stages: input register, per-entry match, group OR, final OR.
// Reset: valid bits and the pipeline clear; busy resets high and the clock clears it after release.
// The receiver cannot stall, so busy never rises again after reset.
module ip_prefix_blacklist_match_unit
	import ipbl_pkg::*;
#(
	parameter int V4_ENTRIES = V4_ENTRIES_DEF,
	parameter int V6_ENTRIES = V6_ENTRIES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CMD_W-1:0]  cmd,
	input  logic              is_v6,
	input  logic [HALF_W-1:0] addr_hi,
	input  logic [HALF_W-1:0] addr_lo,
	input  logic [PLEN_W-1:0] pfx_len,
	input  logic [IDX_W-1:0]  entry_index,
	input  logic              entry_valid,
	output logic              done,
	output logic              blocked
);

	localparam int NGRP4 = (V4_ENTRIES + GRP - 1) / GRP;
	localparam int NGRP6 = (V6_ENTRIES + GRP - 1) / GRP;

	logic               busy_q;
	logic               accept;
	logic [ADDR6_W-1:0] mask_w;
	tbl_wr_t            wr4;
	tbl_wr_t            wr6;
	logic               vld_s1, vld_s2, vld_s3, vld_s4;
	logic               chk4_s1, chk6_s1;
	logic [ADDR6_W-1:0] addr_s1;
	logic [NGRP4-1:0]   grp4_s3;
	logic [NGRP6-1:0]   grp6_s3;
	logic               blocked_s4;

	assign accept = start && !busy_q;
	assign busy = busy_q;

	// Busy from reset until the clock clears it after release.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	// Table writes take effect at the accepting edge, ahead of any later check.
	assign mask_w = prefix_mask(pfx_len);

	always_comb begin
		wr4.en = accept && (cmd == CMD_WR4);
		wr4.index = entry_index;
		wr4.valid = entry_valid;
		wr6.en = accept && (cmd == CMD_WR6);
		wr6.index = entry_index;
		wr6.valid = entry_valid;
	end

	// Stage 1: capture the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			chk4_s1 <= 1'b0;
			chk6_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			chk4_s1 <= accept && (cmd == CMD_CHECK) && !is_v6;
			chk6_s1 <= accept && (cmd == CMD_CHECK) && is_v6;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= {addr_hi, addr_lo};
		end
	end

	ipbl_table #(
		.ENTRIES (V4_ENTRIES),
		.AW      (ADDR4_W)
	) u_tbl4 (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr4),
		.wr_addr  (addr_lo[ADDR4_W-1:0]),
		.wr_mask  (mask_w[ADDR6_W-1 -: ADDR4_W]),
		.chk_en   (chk4_s1),
		.chk_addr (addr_s1[ADDR4_W-1:0]),
		.grp_s3   (grp4_s3)
	);

	ipbl_table #(
		.ENTRIES (V6_ENTRIES),
		.AW      (ADDR6_W)
	) u_tbl6 (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr6),
		.wr_addr  ({addr_hi, addr_lo}),
		.wr_mask  (mask_w),
		.chk_en   (chk6_s1),
		.chk_addr (addr_s1),
		.grp_s3   (grp6_s3)
	);

	// Valid bits follow the tables' stages; stage 4 folds the groups.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			blocked_s4 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			blocked_s4 <= (|grp4_s3) || (|grp6_s3);
		end
	end

	assign done = vld_s4;
	assign blocked = blocked_s4 && vld_s4;

	// Every accepted beat gives exactly one strobe on done.
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("accepted beat produced no result");

	a_done_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, 4))
		else $error("result strobe without an accepted beat");

	// Writes and unused commands never report a block.
	a_write_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd != CMD_CHECK)) |-> ##4 (done && !blocked))
		else $error("non-check beat reported blocked");

	// No group match can appear without a check in flight.
	a_grp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		((|grp4_s3) || (|grp6_s3)) |-> $past(chk4_s1 || chk6_s1, 2))
		else $error("match without a check beat");

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ipbl_pkg::*;

	// Command code the block leaves unused.
	localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
	localparam int LATENCY = 4;
	localparam int N4 = V4_ENTRIES_DEF;
	localparam int N6 = V6_ENTRIES_DEF;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [CMD_W-1:0]  cmd;
	logic              is_v6;
	logic [HALF_W-1:0] addr_hi;
	logic [HALF_W-1:0] addr_lo;
	logic [PLEN_W-1:0] pfx_len;
	logic [IDX_W-1:0]  entry_index;
	logic              entry_valid;
	logic              done;
	logic              blocked;

	ip_prefix_blacklist_match_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.is_v6      (is_v6),
		.addr_hi    (addr_hi),
		.addr_lo    (addr_lo),
		.pfx_len    (pfx_len),
		.entry_index(entry_index),
		.entry_valid(entry_valid),
		.done       (done),
		.blocked    (blocked)
	);

	// One verdict is owed for every accepted beat, in order.
	typedef struct {
		logic        blocked;
		int unsigned beat_no;
	} verdict_t;

	verdict_t    verdicts_due[$];
	int unsigned beats_sent;
	int unsigned mismatches;
	int unsigned idle_pct;

	// Shadow copy of both prefix tables.
	logic              v4_on[N4];
	logic [ADDR4_W-1:0] v4_net[N4];
	logic [5:0]        v4_len[N4];
	logic              v6_on[N6];
	logic [ADDR6_W-1:0] v6_net[N6];
	logic [PLEN_W-1:0] v6_len[N6];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Applies one beat to the shadow tables and returns the verdict it earns.
	function automatic logic filter_verdict(input logic [CMD_W-1:0] c, input logic fam6,
			input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
			input logic [PLEN_W-1:0] plen, input logic [IDX_W-1:0] idx, input logic valid);
		logic hit;
		logic [ADDR4_W-1:0] m4;
		logic [ADDR6_W-1:0] m6;
		logic [ADDR6_W-1:0] a6;
		hit = 1'b0;
		a6 = {hi, lo};
		case (c)
			CMD_CHECK: begin
				if (fam6) begin
					for (int i = 0; i < N6; i++) begin
						if (v6_on[i]) begin
							m6 = ~({ADDR6_W{1'b1}} >> v6_len[i]);
							if (((a6 ^ v6_net[i]) & m6) == '0) hit = 1'b1;
						end
					end
				end else begin
					for (int i = 0; i < N4; i++) begin
						if (v4_on[i]) begin
							m4 = ~({ADDR4_W{1'b1}} >> v4_len[i]);
							if (((lo[ADDR4_W-1:0] ^ v4_net[i]) & m4) == '0) hit = 1'b1;
						end
					end
				end
			end
			CMD_WR4: begin
				if (int'(idx) < N4) begin
					v4_net[idx] = lo[ADDR4_W-1:0];
					v4_len[idx] = (plen > 8'd32) ? 6'd32 : plen[5:0];
					v4_on[idx] = valid;
				end
			end
			CMD_WR6: begin
				if (int'(idx) < N6) begin
					v6_net[idx] = a6;
					v6_len[idx] = (plen > 8'd128) ? 8'd128 : plen;
					v6_on[idx] = valid;
				end
			end
			default: begin
			end
		endcase
		return hit;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// Sends one beat after a random number of idle cycles and books its verdict.
	task automatic send_beat(input logic [CMD_W-1:0] c, input logic fam6,
			input logic [HALF_W-1:0] hi, input logic [HALF_W-1:0] lo,
			input logic [PLEN_W-1:0] plen, input logic [IDX_W-1:0] idx, input logic valid);
		verdict_t v;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		cmd         <= c;
		is_v6       <= fam6;
		addr_hi     <= hi;
		addr_lo     <= lo;
		pfx_len     <= plen;
		entry_index <= idx;
		entry_valid <= valid;
		do @(posedge clk); while (busy);
		v.blocked = filter_verdict(c, fam6, hi, lo, plen, idx, valid);
		v.beat_no = beats_sent;
		verdicts_due = {verdicts_due, v};
		beats_sent++;
	endtask

	// Each strobed result is matched against the oldest verdict owed.
	always @(posedge clk) begin
		verdict_t due;
		if (arst_n && done) begin
			if (verdicts_due.size() == 0) begin
				report_mismatch($sformatf("result strobe with no beat outstanding, blocked %b",
					blocked));
			end else begin
				due = verdicts_due.pop_front();
				if (blocked !== due.blocked) begin
					report_mismatch($sformatf("beat %0d: blocked %b, expected %b",
						due.beat_no, blocked, due.blocked));
				end
			end
		end
	end

	function automatic logic [PLEN_W-1:0] pick_prefix(input int unsigned top);
		case ($urandom_range(19))
			0: return 8'd0;
			1: return PLEN_W'(top);
			2, 3: return PLEN_W'($urandom_range(255));
			4: return PLEN_W'($urandom_range(66, 62));
			default: return PLEN_W'($urandom_range(top, top / 4));
		endcase
	endfunction

	function automatic logic [HALF_W-1:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Both empty tables must pass the all-zeros and all-ones addresses.
	task automatic test_empty_tables();
		send_beat(CMD_CHECK, 1'b0, '0, '0, 8'd0, 4'd0, 1'b0);
		send_beat(CMD_CHECK, 1'b0, '1, '1, 8'hFF, 4'hF, 1'b1);
		send_beat(CMD_CHECK, 1'b1, '0, '0, 8'd0, 4'd0, 1'b0);
		send_beat(CMD_CHECK, 1'b1, '1, '1, 8'hFF, 4'hF, 1'b1);
	endtask

	// IPv4 prefixes, ignored upper bits, saturation to 32 and removal.
	task automatic test_v4_prefixes();
		send_beat(CMD_WR4, 1'b1, '1, {32'hDEAD_BEEF, 32'hC0A8_0000}, 8'd16, 4'd0, 1'b1);
		send_beat(CMD_CHECK, 1'b0, rand64(), {32'h1234_5678, 32'hC0A8_FF01}, 8'd0, 4'd3, 1'b0);
		send_beat(CMD_CHECK, 1'b0, '0, {32'h0, 32'hC0A9_0000}, 8'd16, 4'd0, 1'b1);
		send_beat(CMD_WR4, 1'b0, '0, {32'hFFFF_FFFF, 32'h0A00_0001}, 8'd200, 4'd15, 1'b1);
		send_beat(CMD_CHECK, 1'b0, '1, {32'h0, 32'h0A00_0001}, 8'd0, 4'd0, 1'b0);
		send_beat(CMD_CHECK, 1'b0, '0, {32'h0, 32'h0A00_0000}, 8'd0, 4'd0, 1'b0);
		send_beat(CMD_WR4, 1'b0, '0, {32'h0, 32'hC0A8_0000}, 8'd16, 4'd0, 1'b0);
		send_beat(CMD_CHECK, 1'b0, '0, {32'h0, 32'hC0A8_0101}, 8'd0, 4'd0, 1'b0);
	endtask

	// IPv6 prefixes across the half boundary and saturation to 128.
	task automatic test_v6_prefixes();
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
		hi = 64'h2001_0DB8_AAAA_5555;
		lo = 64'h8000_0000_0000_1234;
		send_beat(CMD_WR6, 1'b0, hi, lo, 8'd65, 4'd3, 1'b1);
		send_beat(CMD_CHECK, 1'b1, hi, lo ^ 64'h4000_0000_0000_0000, 8'd0, 4'd0, 1'b0);
		send_beat(CMD_CHECK, 1'b1, hi, lo ^ 64'h8000_0000_0000_0000, 8'd0, 4'd0, 1'b0);
		send_beat(CMD_WR6, 1'b1, '1, '1, 8'hFF, 4'd9, 1'b1);
		send_beat(CMD_CHECK, 1'b1, '1, '1, 8'd0, 4'd0, 1'b0);
		send_beat(CMD_CHECK, 1'b1, '1, 64'hFFFF_FFFF_FFFF_FFFE, 8'd0, 4'd0, 1'b0);
	endtask

	// A zero prefix matches its whole family; the unused command answers 0.
	task automatic test_match_all();
		send_beat(CMD_WR4, 1'b1, rand64(), rand64(), 8'd0, 4'd5, 1'b1);
		send_beat(CMD_CHECK, 1'b0, rand64(), rand64(), 8'd0, 4'd0, 1'b0);
		send_beat(CMD_CHECK, 1'b1, '0, '0, 8'd0, 4'd0, 1'b0);
		send_beat(CMD_WR6, 1'b0, rand64(), rand64(), 8'd0, 4'd0, 1'b1);
		send_beat(CMD_CHECK, 1'b1, '0, '0, 8'd0, 4'd0, 1'b0);
		send_beat(CMD_NOP, 1'b1, '1, '1, 8'hFF, 4'hF, 1'b1);
		send_beat(CMD_WR4, 1'b0, '0, '0, 8'd0, 4'd5, 1'b0);
		send_beat(CMD_WR6, 1'b1, '0, '0, 8'd0, 4'd0, 1'b0);
	endtask

	// Clears both tables, then mixes writes, unused commands and checks, most aimed near stored networks.
	task automatic test_random(input int unsigned idle, input int unsigned count);
		int unsigned pick;
		logic [6:0] k;
		logic [CMD_W-1:0] c;
		logic fam6;
		logic valid;
		logic [HALF_W-1:0] hi;
		logic [HALF_W-1:0] lo;
		logic [ADDR6_W-1:0] a6;
		logic [PLEN_W-1:0] plen;
		logic [IDX_W-1:0] idx;
		idle_pct = idle;
		for (int i = 0; i < N4; i++) begin
			send_beat(CMD_WR4, 1'($urandom_range(1)), rand64(), rand64(), pick_prefix(32),
				IDX_W'(i), 1'b0);
		end
		for (int i = 0; i < N6; i++) begin
			send_beat(CMD_WR6, 1'($urandom_range(1)), rand64(), rand64(), pick_prefix(128),
				IDX_W'(i), 1'b0);
		end
		for (int unsigned n = 0; n < count; n++) begin
			hi = rand64();
			lo = rand64();
			idx = IDX_W'($urandom_range(15));
			fam6 = 1'($urandom_range(1));
			valid = ($urandom_range(9) < 6);
			plen = PLEN_W'($urandom_range(255));
			pick = $urandom_range(99);
			if (pick < 12) begin
				c = CMD_WR4;
				plen = pick_prefix(32);
			end else if (pick < 24) begin
				c = CMD_WR6;
				plen = pick_prefix(128);
			end else if (pick < 28) begin
				c = CMD_NOP;
			end else begin
				c = CMD_CHECK;
				// Aim most checks at a stored network, one bit off or exact.
				if ($urandom_range(2) != 0) begin
					if (fam6) begin
						a6 = v6_net[idx];
						if ($urandom_range(1)) begin
							k = 7'($urandom_range(127));
							a6[k] = ~a6[k];
						end
						hi = a6[ADDR6_W-1:HALF_W];
						lo = a6[HALF_W-1:0];
					end else begin
						lo[ADDR4_W-1:0] = v4_net[idx];
						if ($urandom_range(1)) begin
							k = 7'($urandom_range(31));
							lo[k[5:0]] = ~lo[k[5:0]];
						end
					end
				end
			end
			send_beat(c, fam6, hi, lo, plen, idx, valid);
		end
	endtask

	initial begin
		#5_000_000;
		$display("ip_prefix_blacklist_match_unit: mismatch");
		$finish;
	end

	initial begin
		for (int i = 0; i < N4; i++) begin
			v4_on[i] = 1'b0;
			v4_net[i] = '0;
			v4_len[i] = '0;
		end
		for (int i = 0; i < N6; i++) begin
			v6_on[i] = 1'b0;
			v6_net[i] = '0;
			v6_len[i] = '0;
		end
		beats_sent = 0;
		mismatches = 0;
		idle_pct = 12;
		arst_n      <= 1'b0;
		start       <= 1'b0;
		cmd         <= CMD_CHECK;
		is_v6       <= 1'b0;
		addr_hi     <= '0;
		addr_lo     <= '0;
		pfx_len     <= '0;
		entry_index <= '0;
		entry_valid <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_tables();
		test_v4_prefixes();
		test_v6_prefixes();
		test_match_all();
		test_random(12, 310);
		test_random(62, 310);
		test_random(0, 310);
		start <= 1'b0;

		// Drain the pipeline, then watch a little longer for stray strobes.
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (mismatches == 0) begin
			$display("ip_prefix_blacklist_match_unit: match");
		end else begin
			$display("ip_prefix_blacklist_match_unit: mismatch");
		end
		$finish;
	end

endmodule
